/* rtl/core/sle_pkg.sv */
// Shared types, codes and constants for the serial line editor receiver.
// No dependencies; imported by the top level, sle_ctrl and sle_emit.
package sle_pkg;

    // default line buffer depth
    localparam int BUF_DEPTH_DEF = 4096;

    // request function codes
    localparam logic [1:0] FUNC_RX   = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_TAKE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_TAKE = 2'd2;

    // character codes
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_FILL     = 8'hff;
    localparam logic [7:0] CH_P        = 8'h50;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd127;

    // result step counter within one request
    localparam int STEP_W = 3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  rx_byte;
        logic [11:0] read_index;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [11:0] line_length;
        logic        enter_pressed;
        logic        last;
    } t_out_res;

    // result burst produced by one request
    typedef enum logic [2:0] {
        OP_ECHO  = 3'd0,  // echo of one stored byte
        OP_CRLF  = 3'd1,  // CR LF echo with enter flag
        OP_ERASE = 3'd2,  // five byte erase sequence
        OP_READ  = 3'd3,  // buffer read data
        OP_TAKE  = 3'd4   // taken line length
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  data;
        logic [11:0] len;
        logic        inrange;
    } t_desc;

    // status of the result stage, watched at the top level
    typedef struct packed {
        logic busy;
        logic last_step;
    } t_emit_stat;

    // index of the final result of a burst
    function automatic logic [STEP_W-1:0] op_last_step(input t_op op);
        logic [STEP_W-1:0] s;
        case (op)
            OP_CRLF:  s = STEP_W'(1);
            OP_ERASE: s = STEP_W'(4);
            default:  s = '0;
        endcase
        return s;
    endfunction

    // erase sequence: BS ESC [ FF P
    function automatic logic [7:0] erase_byte(input logic [STEP_W-1:0] step);
        logic [7:0] b;
        case (step)
            STEP_W'(0): b = CH_BS;
            STEP_W'(1): b = CH_ESC;
            STEP_W'(2): b = CH_LBRACKET;
            STEP_W'(3): b = CH_FILL;
            default:    b = CH_P;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/serial_line_editor_receiver.sv */
// Serial line editor receiver: top level, ties decode, line buffer and results.
// Depends on sle_pkg, sle_line_mem, sle_ctrl and sle_emit.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready / i_in_data) carries received
//   bytes, buffer reads and line takes. Result channel (o_out_valid /
//   i_out_ready / o_out_data) returns echo bytes, read data and line lengths;
//   the final result of each request has last set. Requests that cause no
//   result (ignored bytes, escape swallowing, CR LF framing) give nothing. Config
//   channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets the framing mode, is
//   always ready, and must be written only while the block is idle (unenforced).
// Timing:
//   The first result of a request passes the burst stage, then the output
//   register, and can then be taken. A request with several results holds the
//   burst stage until its last result moves on, so single-result requests run
//   at one per cycle while i_out_ready holds; CR in editor mode gives two
//   results, backspace five. The line buffer has one write and one read
//   port, each used at most once per request.
// Reset: line state and mode clear at once; buffer contents need no clearing,
//   so requests are taken from the first cycle after reset.
// Stall: a held result keeps the output register; the burst stage and then
//   o_in_ready back up until i_out_ready returns.
module serial_line_editor_receiver #(
    parameter int BUF_DEPTH = sle_pkg::BUF_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sle_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sle_pkg::t_out_res o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);
    import sle_pkg::*;

    localparam int CW = $clog2(BUF_DEPTH);

    logic          req_acc;
    logic          emit_free;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          desc_load;
    t_desc         desc;
    t_emit_stat    emit_stat;

    assign o_in_ready  = emit_free;
    assign o_cfg_ready = 1'b1;
    assign req_acc     = i_in_valid && emit_free;

    sle_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_mode  (i_cfg_data),
        .i_req_acc   (req_acc),
        .i_req       (i_in_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_desc_load (desc_load),
        .o_desc      (desc)
    );

    sle_line_mem #(
        .DEPTH (BUF_DEPTH),
        .AW    (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sle_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (desc_load),
        .i_desc    (desc),
        .i_rd_data (rd_data),
        .o_free    (emit_free),
        .o_stat    (emit_stat),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_res     (o_out_data)
    );

`ifndef ASSERT_OFF
    // reads and takes always load a result burst
    a_req_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && (i_in_data.func == FUNC_READ || i_in_data.func == FUNC_TAKE)
        |=> emit_stat.busy)
        else $error("read or take request produced no burst");

    // read and take results are single
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_ECHO |-> o_out_data.last)
        else $error("read or take result without last");

    // enter flag only on the CR LF echo
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.enter_pressed
        |-> o_out_data.kind == KIND_ECHO
            && (o_out_data.out_byte == CH_CR || o_out_data.out_byte == CH_LF))
        else $error("enter flag on a result other than CR LF echo");

    // a take result carries no byte
    a_take_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_TAKE |-> o_out_data.out_byte == 8'd0)
        else $error("take result with nonzero byte");
`endif

endmodule

/* rtl/core/sle_line_mem.sv */
// Line buffer storage: one write port, one read port, registered read data.
// Depends on nothing; instanced by the top level.
module sle_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/sle_ctrl.sv */
// Request decode and line state: count, flags, mode; drives buffer accesses.
// Depends on sle_pkg.
module sle_ctrl #(
    parameter int BUF_DEPTH = 4096,
    parameter int CW        = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_mode,
    input  logic             i_req_acc,
    input  sle_pkg::t_in_req i_req,
    output logic             o_wr_en,
    output logic [CW-1:0]    o_wr_addr,
    output logic [7:0]       o_wr_data,
    output logic             o_rd_en,
    output logic [CW-1:0]    o_rd_addr,
    output logic             o_desc_load,
    output sle_pkg::t_desc   o_desc
);
    import sle_pkg::*;

    localparam int CMPW = (CW > 12) ? CW : 12;
    localparam logic [CW-1:0] COUNT_TOP = CW'(BUF_DEPTH - 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_complete, n_complete;
    logic          r_cr_seen, n_cr_seen;
    logic          r_esc_active, n_esc_active;
    logic          r_esc_skipped, n_esc_skipped;
    logic          r_mode;

    logic   store;
    logic   emit;
    t_desc  desc;
    logic [7:0] b;

    assign b = i_req.rx_byte;

    // next line state and result burst for the accepted request
    always_comb begin
        n_count       = r_count;
        n_complete    = r_complete;
        n_cr_seen     = r_cr_seen;
        n_esc_active  = r_esc_active;
        n_esc_skipped = r_esc_skipped;
        store         = 1'b0;
        emit          = 1'b0;
        desc.op       = OP_ECHO;
        desc.data     = b;
        desc.len      = '0;
        desc.inrange  = 1'b0;
        case (i_req.func)
            FUNC_RX: begin
                if (!r_complete) begin
                    if (!r_mode) begin
                        // editor mode
                        if (r_esc_active) begin
                            n_esc_skipped = !r_esc_skipped;
                            n_esc_active  = !r_esc_skipped;
                        end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
                            emit  = 1'b1;
                            store = 1'b1;
                        end else if (b == CH_CR) begin
                            if (r_count != '0) begin
                                n_complete = 1'b1;
                            end
                            emit    = 1'b1;
                            desc.op = OP_CRLF;
                        end else if (b == CH_BS) begin
                            if (r_count != '0) begin
                                emit    = 1'b1;
                                desc.op = OP_ERASE;
                                n_count = r_count - CW'(1);
                            end
                        end else if (b == CH_ESC) begin
                            n_esc_active = 1'b1;
                        end
                    end else begin
                        // CR LF framing
                        if (r_cr_seen) begin
                            if (b != CH_LF) begin
                                n_count   = '0;
                                n_cr_seen = 1'b0;
                            end else begin
                                n_complete = 1'b1;
                            end
                        end else if (b == CH_CR) begin
                            n_cr_seen = 1'b1;
                        end else begin
                            store = 1'b1;
                        end
                    end
                end
                // store and overflow restart
                if (store) begin
                    if (r_count == COUNT_TOP) begin
                        n_count   = '0;
                        n_cr_seen = 1'b0;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            FUNC_READ: begin
                emit         = 1'b1;
                desc.op      = OP_READ;
                desc.inrange = CMPW'(i_req.read_index) < CMPW'(r_count);
            end
            FUNC_TAKE: begin
                emit    = 1'b1;
                desc.op = OP_TAKE;
                if (r_complete) begin
                    desc.len   = 12'(r_count);
                    n_count    = '0;
                    n_cr_seen  = 1'b0;
                    n_complete = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_complete    <= 1'b0;
            r_cr_seen     <= 1'b0;
            r_esc_active  <= 1'b0;
            r_esc_skipped <= 1'b0;
        end else if (i_req_acc) begin
            r_count       <= n_count;
            r_complete    <= n_complete;
            r_cr_seen     <= n_cr_seen;
            r_esc_active  <= n_esc_active;
            r_esc_skipped <= n_esc_skipped;
        end
    end

    // framing mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
        end
    end

    // buffer accesses
    assign o_wr_en     = i_req_acc && store;
    assign o_wr_addr   = r_count;
    assign o_wr_data   = b;
    assign o_rd_en     = i_req_acc && (i_req.func == FUNC_READ);
    assign o_rd_addr   = CW'(i_req.read_index);
    assign o_desc_load = i_req_acc && emit;
    assign o_desc      = desc;

endmodule

/* rtl/core/sle_emit.sv */
// Result stage: holds one request's burst and steps it into the output register.
// Depends on sle_pkg; read data comes from the line buffer.
module sle_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sle_pkg::t_desc      i_desc,
    input  logic [7:0]          i_rd_data,
    output logic                o_free,
    output sle_pkg::t_emit_stat o_stat,
    output logic                o_valid,
    input  logic                i_ready,
    output sle_pkg::t_out_res   o_res
);
    import sle_pkg::*;

    logic              r_a_valid;
    t_desc             r_a_desc;
    logic [STEP_W-1:0] r_a_step;
    logic              r_o_valid;
    t_out_res          r_o_res;

    t_out_res cur;
    logic     o_free_slot;
    logic     a_adv;
    logic     a_last;

    // current result of the held burst
    always_comb begin
        cur               = '0;
        cur.kind          = KIND_ECHO;
        cur.out_byte      = r_a_desc.data;
        cur.line_length   = '0;
        cur.enter_pressed = 1'b0;
        case (r_a_desc.op)
            OP_ECHO: begin
            end
            OP_CRLF: begin
                cur.out_byte      = (r_a_step == '0) ? CH_CR : CH_LF;
                cur.enter_pressed = 1'b1;
            end
            OP_ERASE: begin
                cur.out_byte = erase_byte(r_a_step);
            end
            OP_READ: begin
                cur.kind     = KIND_READ;
                cur.out_byte = r_a_desc.inrange ? i_rd_data : 8'd0;
            end
            OP_TAKE: begin
                cur.kind        = KIND_TAKE;
                cur.out_byte    = 8'd0;
                cur.line_length = r_a_desc.len;
            end
            default: begin
            end
        endcase
        cur.last = a_last;
    end

    assign a_last      = (r_a_step == op_last_step(r_a_desc.op));
    assign o_free_slot = !r_o_valid || i_ready;
    assign a_adv       = r_a_valid && o_free_slot;
    assign o_free      = !r_a_valid || (a_adv && a_last);

    // burst holding stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_step  <= '0;
        end else if (i_load) begin
            r_a_valid <= 1'b1;
            r_a_step  <= '0;
        end else if (a_adv) begin
            if (a_last) begin
                r_a_valid <= 1'b0;
            end else begin
                r_a_step <= r_a_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_desc <= i_desc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_o_res <= cur;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_res            = r_o_res;
    assign o_stat.busy      = r_a_valid;
    assign o_stat.last_step = a_last;

endmodule
